[rtl/complex_wavelet_correlator_core_macros.svh]
// Assertion macros of the correlator RTL.
`ifndef COMPLEX_WAVELET_CORRELATOR_CORE_MACROS_SVH
`define COMPLEX_WAVELET_CORRELATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define CWC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("correlator assertion failed");
// Next-cycle implication, disabled during reset.
`define CWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("correlator assertion failed");
`else
`define CWC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CWC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/cwc_pkg.sv]
// Shared types, constants and the arctangent table of the wavelet correlator.
`default_nettype none
package cwc_pkg;
   localparam int GAIN_W = 16;
   localparam int TAP_COUNT_W = 7;
   localparam int TAP_INDEX_W = 6;
   localparam int POS_W = 16;
   localparam int MAG_W = 32;
   localparam int PHASE_W = 16;
   localparam int ANGLE_W = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 1;

   // Register indexes of the write port.
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_GAIN = 1'b1;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;
   localparam logic [GAIN_W-1:0] NORM_GAIN_RESET = 16'd8192;
   localparam logic [TAP_COUNT_W-1:0] MIN_TAPS = 7'd4;

   // Input word kinds.
   localparam logic KIND_TAP = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Controls of one window cell.
   typedef struct packed {
      logic clear;
      logic load;
      logic rotate;
   } cell_ctl_type;

   // Arctangent of 2^-step, with 2^31 units per pi.
   function automatic logic [ANGLE_W-1:0] atan_angle(input logic [4:0] step);
      logic [ANGLE_W-1:0] angle;
      case (step)
         5'd0: angle = 32'h20000000;
         5'd1: angle = 32'h12E4051E;
         5'd2: angle = 32'h09FB385B;
         5'd3: angle = 32'h051111D4;
         5'd4: angle = 32'h028B0D43;
         5'd5: angle = 32'h0145D7E1;
         5'd6: angle = 32'h00A2F61E;
         5'd7: angle = 32'h00517C55;
         5'd8: angle = 32'h0028BE53;
         5'd9: angle = 32'h00145F2F;
         5'd10: angle = 32'h000A2F98;
         5'd11: angle = 32'h000517CC;
         5'd12: angle = 32'h00028BE6;
         5'd13: angle = 32'h000145F3;
         5'd14: angle = 32'h0000A2F9;
         5'd15: angle = 32'h0000517C;
         5'd16: angle = 32'h000028BE;
         5'd17: angle = 32'h0000145F;
         5'd18: angle = 32'h00000A2F;
         5'd19: angle = 32'h00000517;
         5'd20: angle = 32'h0000028B;
         5'd21: angle = 32'h00000145;
         5'd22: angle = 32'h000000A2;
         5'd23: angle = 32'h00000051;
         5'd24: angle = 32'h00000028;
         5'd25: angle = 32'h00000014;
         5'd26: angle = 32'h0000000A;
         5'd27: angle = 32'h00000005;
         5'd28: angle = 32'h00000002;
         5'd29: angle = 32'h00000001;
         default: angle = '0;
      endcase
      return angle;
   endfunction
endpackage
`default_nettype wire

[rtl/complex_wavelet_correlator_core.sv]
// Top level of the complex wavelet correlator: one scale row of a wavelet transform.
//
// Input channel (req_*): a word with kind tap writes one complex tap into the tap
// memory. A word with kind sample shifts one sample into a ring of MAX_TAPS cells;
// once enough samples are in, it yields one coefficient, and a sample with last set
// also flushes the remaining coefficients and clears the window. Each coefficient
// rotates the ring once through a single complex MAC while the input stalls. The
// post unit (gain, magnitude root, CORDIC phase) then runs; it overlaps the next
// ring pass, so the post unit sets the rate.
// Result channel (rsp_*): one word per coefficient, held while rsp_stall is high; a
// stalled result blocks the post unit, and the input stalls once that backs up.
// Configuration (csr_*): write while idle; tap_count and norm_gain.
// Reset clears window and sample counter, loads register defaults; taps are undefined.
`default_nettype none
`include "complex_wavelet_correlator_core_macros.svh"
module complex_wavelet_correlator_core #(
   parameter int MAX_TAPS = 64,
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 16,
   parameter int TAP_BITS = 18
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_kind,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input wire logic req_last,
   input wire logic [cwc_pkg::TAP_INDEX_W-1:0] req_tap_index,
   input wire logic signed [TAP_BITS-1:0] req_tap_real,
   input wire logic signed [TAP_BITS-1:0] req_tap_imag,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [cwc_pkg::POS_W-1:0] rsp_position,
   output logic [cwc_pkg::MAG_W-1:0] rsp_magnitude,
   output logic signed [cwc_pkg::PHASE_W-1:0] rsp_phase,
   output logic rsp_final_res,
   input wire logic csr_write,
   input wire logic [cwc_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [cwc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int ADDR_W = $clog2(MAX_TAPS);
   localparam int ACC_W = SAMPLE_BITS + TAP_BITS + $clog2(MAX_TAPS);
   localparam int FRAC = SAMPLE_BITS + TAP_BITS - 5;
   localparam int CNT_W = $clog2(MAX_SAMPLES) + 1;
   localparam int C_W = CNT_W + 1;
   localparam int ROT_W = $clog2(MAX_TAPS + 2);
   localparam int TC_W = cwc_pkg::TAP_COUNT_W;
   localparam int POS_W = cwc_pkg::POS_W;
   localparam logic [TC_W-1:0] TAPS_LIMIT = TC_W'(MAX_TAPS);
   localparam logic [C_W-1:0] CNT_TOP = C_W'((64'd1 << CNT_W) - 64'd1);
   localparam logic [C_W-1:0] CNT_WRAP = C_W'(64'd1 << (CNT_W - 1));
   localparam logic [ROT_W-1:0] ROT_LEN = ROT_W'(MAX_TAPS);
   localparam logic [ROT_W-1:0] ROT_END = ROT_W'(MAX_TAPS + 1);

   typedef enum logic [2:0] {C_IDLE, C_EVAL, C_ROT, C_HAND, C_NEXT} ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic last_ff, last_in;
   logic [TC_W-1:0] flush_ff, flush_in;
   logic [ROT_W-1:0] rot_ff, rot_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic fin_ff, fin_in;
   logic [TC_W-1:0] tap_count_ff, tap_count_in;
   logic [cwc_pkg::GAIN_W-1:0] norm_gain_ff, norm_gain_in;

   logic [TC_W-1:0] taps_eff;
   logic [TC_W-1:0] lookahead;
   logic req_take;
   logic rotating;
   cwc_pkg::cell_ctl_type cell_ctl;
   logic signed [SAMPLE_BITS-1:0] new_sample;
   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_TAPS];
   logic tap_wr;
   logic tap_rd_en;
   logic [ADDR_W-1:0] tap_rd_addr;
   logic acc_clear;
   logic signed [ACC_W-1:0] acc_real;
   logic signed [ACC_W-1:0] acc_imag;
   logic post_start;
   logic post_busy;

   // Effective tap count and the lookahead past the center tap.
   always_comb begin
      if (tap_count_ff < cwc_pkg::MIN_TAPS) begin
         taps_eff = cwc_pkg::MIN_TAPS;
      end else if (tap_count_ff > TAPS_LIMIT) begin
         taps_eff = TAPS_LIMIT;
      end else begin
         taps_eff = tap_count_ff;
      end
      lookahead = taps_eff - TC_W'(1) - (taps_eff >> 1);
   end

   assign req_stall = state_ff != C_IDLE;
   assign req_take = req_valid && !req_stall;
   assign rotating = state_ff == C_ROT && rot_ff < ROT_LEN;
   assign tap_wr = req_take && req_kind == cwc_pkg::KIND_TAP
      && {1'b0, req_tap_index} < TC_W'(MAX_TAPS);
   assign tap_rd_en = rotating && TC_W'(rot_ff) < taps_eff;
   assign tap_rd_addr = tap_rd_en ? ADDR_W'(taps_eff - TC_W'(1) - TC_W'(rot_ff)) : '0;
   assign post_start = state_ff == C_HAND && !post_busy;

   // Sequencer: shift in, evaluate, rotate the ring, hand off, flush.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      last_in = last_ff;
      flush_in = flush_ff;
      rot_in = rot_ff;
      pos_in = pos_ff;
      fin_in = fin_ff;
      cell_ctl = '0;
      new_sample = req_sample;
      acc_clear = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (req_take && req_kind == cwc_pkg::KIND_SAMPLE) begin
               cell_ctl.load = 1'b1;
               cnt_in = (cnt_ff >= CNT_TOP) ? CNT_WRAP : cnt_ff + C_W'(1);
               last_in = req_last;
               flush_in = '0;
               state_in = C_EVAL;
            end
         end
         C_EVAL: begin
            if (cnt_ff > C_W'(lookahead)) begin
               pos_in = POS_W'(cnt_ff - C_W'(lookahead) - C_W'(1));
               fin_in = last_ff && flush_ff == lookahead;
               rot_in = '0;
               acc_clear = 1'b1;
               state_in = C_ROT;
            end else begin
               state_in = C_NEXT;
            end
         end
         C_ROT: begin
            cell_ctl.rotate = rotating;
            rot_in = rot_ff + ROT_W'(1);
            if (rot_ff == ROT_END) begin
               state_in = C_HAND;
            end
         end
         C_HAND: begin
            if (!post_busy) begin
               state_in = C_NEXT;
            end
         end
         C_NEXT: begin
            if (last_ff && flush_ff < lookahead) begin
               cell_ctl.load = 1'b1;
               new_sample = '0;
               cnt_in = cnt_ff + C_W'(1);
               flush_in = flush_ff + TC_W'(1);
               state_in = C_EVAL;
            end else if (last_ff) begin
               cell_ctl.clear = 1'b1;
               cnt_in = '0;
               last_in = 1'b0;
               state_in = C_IDLE;
            end else begin
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      tap_count_in = tap_count_ff;
      norm_gain_in = norm_gain_ff;
      if (csr_write) begin
         case (csr_index)
            cwc_pkg::CSR_TAP_COUNT: tap_count_in = csr_wdata[TC_W-1:0];
            cwc_pkg::CSR_NORM_GAIN: norm_gain_in = csr_wdata;
            default: begin
               tap_count_in = tap_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff <= '0;
         last_ff <= 1'b0;
         flush_ff <= '0;
         rot_ff <= '0;
         tap_count_ff <= cwc_pkg::TAP_COUNT_RESET;
         norm_gain_ff <= cwc_pkg::NORM_GAIN_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         last_ff <= last_in;
         flush_ff <= flush_in;
         rot_ff <= rot_in;
         tap_count_ff <= tap_count_in;
         norm_gain_ff <= norm_gain_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      fin_ff <= fin_in;
   end

   // Ring of window cells; cell 0 takes new samples and feeds the MAC.
   for (genvar gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] prev_value;
      if (gi == 0) begin : g_head
         assign prev_value = new_sample;
      end else begin : g_body
         assign prev_value = cell_value[gi-1];
      end
      cwc_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(cell_ctl),
         .from_prev(prev_value),
         .from_next(cell_value[(gi + 1) % MAX_TAPS]),
         .value(cell_value[gi])
      );
   end

   cwc_mac #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .TAP_BITS(TAP_BITS),
      .MAX_TAPS(MAX_TAPS)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .wr_en(tap_wr),
      .wr_addr(ADDR_W'(req_tap_index)),
      .wr_real(req_tap_real),
      .wr_imag(req_tap_imag),
      .rd_en(tap_rd_en),
      .rd_addr(tap_rd_addr),
      .sample(cell_value[0]),
      .clear(acc_clear),
      .acc_real(acc_real),
      .acc_imag(acc_imag)
   );

   cwc_post #(
      .ACC_W(ACC_W),
      .FRAC(FRAC)
   ) u_post (
      .clock(clock),
      .reset(reset),
      .start(post_start),
      .sum_real(acc_real),
      .sum_imag(acc_imag),
      .pos(pos_ff),
      .fin(fin_ff),
      .gain(norm_gain_ff),
      .busy(post_busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_position(rsp_position),
      .rsp_magnitude(rsp_magnitude),
      .rsp_phase(rsp_phase),
      .rsp_final_res(rsp_final_res)
   );

   // A tap word never starts work; a sample word always does.
   `CWC_ASSERT_NEXT(a_tap_load_quick, clock, reset, req_take && req_kind == cwc_pkg::KIND_TAP, !req_stall)
   `CWC_ASSERT_NEXT(a_sample_starts, clock, reset, req_take && req_kind == cwc_pkg::KIND_SAMPLE, req_stall)
   // The post unit is only started when free.
   `CWC_ASSERT_IMPLY(a_post_free, clock, reset, post_start, !post_busy)
endmodule
`default_nettype wire

[rtl/cwc_cell.sv]
// One cell of the sample window ring: holds one sample.
`default_nettype none
module cwc_cell #(
   parameter int WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire cwc_pkg::cell_ctl_type ctl,
   input wire logic signed [WIDTH-1:0] from_prev,
   input wire logic signed [WIDTH-1:0] from_next,
   output logic signed [WIDTH-1:0] value
);
   logic signed [WIDTH-1:0] value_ff;
   logic signed [WIDTH-1:0] value_in;

   // Clear wins over a shift-in, which wins over a ring rotation.
   always_comb begin
      value_in = value_ff;
      if (ctl.clear) begin
         value_in = '0;
      end else if (ctl.load) begin
         value_in = from_prev;
      end else if (ctl.rotate) begin
         value_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;
endmodule
`default_nettype wire

[rtl/cwc_mac.sv]
// Tap memory and complex multiply-accumulate fed one sample per cycle.
`default_nettype none
module cwc_mac #(
   parameter int SAMPLE_BITS = 16,
   parameter int TAP_BITS = 18,
   parameter int MAX_TAPS = 64,
   localparam int ADDR_W = $clog2(MAX_TAPS),
   localparam int PROD_W = SAMPLE_BITS + TAP_BITS,
   localparam int ACC_W = PROD_W + $clog2(MAX_TAPS)
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic wr_en,
   input wire logic [ADDR_W-1:0] wr_addr,
   input wire logic signed [TAP_BITS-1:0] wr_real,
   input wire logic signed [TAP_BITS-1:0] wr_imag,
   input wire logic rd_en,
   input wire logic [ADDR_W-1:0] rd_addr,
   input wire logic signed [SAMPLE_BITS-1:0] sample,
   input wire logic clear,
   output logic signed [ACC_W-1:0] acc_real,
   output logic signed [ACC_W-1:0] acc_imag
);
   logic signed [TAP_BITS-1:0] tap_mem_real [MAX_TAPS];
   logic signed [TAP_BITS-1:0] tap_mem_imag [MAX_TAPS];
   logic signed [TAP_BITS-1:0] tap_real_ff;
   logic signed [TAP_BITS-1:0] tap_imag_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [PROD_W-1:0] prod_real_ff;
   logic signed [PROD_W-1:0] prod_imag_ff;
   logic en1_ff;
   logic en2_ff;
   logic signed [ACC_W-1:0] acc_real_ff;
   logic signed [ACC_W-1:0] acc_imag_ff;
   logic signed [ACC_W-1:0] acc_real_in;
   logic signed [ACC_W-1:0] acc_imag_in;

   // Tap memory with registered read, then the product stage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tap_mem_real[wr_addr] <= wr_real;
         tap_mem_imag[wr_addr] <= wr_imag;
      end
      tap_real_ff <= tap_mem_real[rd_addr];
      tap_imag_ff <= tap_mem_imag[rd_addr];
      sample_ff <= sample;
      prod_real_ff <= sample_ff * tap_real_ff;
      prod_imag_ff <= sample_ff * tap_imag_ff;
   end

   // Accumulate products that belong to the current coefficient.
   always_comb begin
      acc_real_in = acc_real_ff;
      acc_imag_in = acc_imag_ff;
      if (clear) begin
         acc_real_in = '0;
         acc_imag_in = '0;
      end else if (en2_ff) begin
         acc_real_in = acc_real_ff + ACC_W'(prod_real_ff);
         acc_imag_in = acc_imag_ff + ACC_W'(prod_imag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en1_ff <= 1'b0;
         en2_ff <= 1'b0;
         acc_real_ff <= '0;
         acc_imag_ff <= '0;
      end else begin
         en1_ff <= rd_en;
         en2_ff <= en1_ff;
         acc_real_ff <= acc_real_in;
         acc_imag_ff <= acc_imag_in;
      end
   end

   assign acc_real = acc_real_ff;
   assign acc_imag = acc_imag_ff;
endmodule
`default_nettype wire

[rtl/cwc_post.sv]
// Gain, magnitude root and CORDIC phase of one coefficient, plus the result register.
`default_nettype none
module cwc_post #(
   parameter int ACC_W = 40,
   parameter int FRAC = 29
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic signed [ACC_W-1:0] sum_real,
   input wire logic signed [ACC_W-1:0] sum_imag,
   input wire logic [cwc_pkg::POS_W-1:0] pos,
   input wire logic fin,
   input wire logic [cwc_pkg::GAIN_W-1:0] gain,
   output logic busy,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [cwc_pkg::POS_W-1:0] rsp_position,
   output logic [cwc_pkg::MAG_W-1:0] rsp_magnitude,
   output logic signed [cwc_pkg::PHASE_W-1:0] rsp_phase,
   output logic rsp_final_res
);
   localparam int GAIN_W = cwc_pkg::GAIN_W;
   localparam int MAG_W = cwc_pkg::MAG_W;
   localparam int ANGLE_W = cwc_pkg::ANGLE_W;
   localparam int GP_W = ACC_W + GAIN_W;
   localparam int X_W = GP_W + 1 - FRAC;
   localparam int ROOT_N = X_W + 1;
   localparam int SQ_W = 2 * ROOT_N;
   localparam int REM_W = ROOT_N + 3;
   localparam int NW = (ACC_W > 31) ? ACC_W : 31;
   localparam int CW = 33;
   localparam int STEP_W = 6;
   localparam logic [GP_W:0] HALF = {{GP_W{1'b0}}, 1'b1} << (FRAC - 1);
   localparam logic [ANGLE_W-1:0] ANGLE_PI = 32'h80000000;
   localparam logic [ANGLE_W-1:0] ANGLE_ROUND = 32'h00008000;

   typedef enum logic [3:0] {
      P_IDLE, P_GAIN, P_RND, P_SQR, P_SUM, P_ROOT, P_NORM, P_CORD, P_FIN, P_OUT
   } post_state_type;

   post_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [GP_W-1:0] mr_ff, mr_in, mi_ff, mi_in;
   logic [GAIN_W-1:0] gsh_ff, gsh_in;
   logic [GP_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [X_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [2*X_W-1:0] xx_ff, xx_in, yy_ff, yy_in;
   logic [SQ_W-1:0] sq_ff, sq_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [ROOT_N-1:0] root_ff, root_in;
   logic [NW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [ANGLE_W-1:0] z_ff, z_in;
   logic re_neg_ff, re_neg_in, im_neg_ff, im_neg_in, zero_ff, zero_in;
   logic [cwc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic fin_ff, fin_in;
   logic signed [cwc_pkg::PHASE_W-1:0] phase_ff, phase_in;

   logic [ACC_W-1:0] abs_re, abs_im;
   logic [GP_W:0] rnd_x, rnd_y;
   logic [REM_W-1:0] rem_cat, trial;
   logic [NW-1:0] or_v;
   logic signed [CW-1:0] sx, sy;
   logic [ANGLE_W-1:0] ang, z_quad, z_sign, z_round;

   always_comb begin
      abs_re = sum_real[ACC_W-1] ? $unsigned(-sum_real) : $unsigned(sum_real);
      abs_im = sum_imag[ACC_W-1] ? $unsigned(-sum_imag) : $unsigned(sum_imag);
      rnd_x = {1'b0, gx_ff} + HALF;
      rnd_y = {1'b0, gy_ff} + HALF;
      rem_cat = {rem_ff[REM_W-3:0], sq_ff[SQ_W-1 -: 2]};
      trial = REM_W'({root_ff, 2'b01});
      or_v = px_ff | py_ff;
      sx = cx_ff >>> step_ff[4:0];
      sy = cy_ff >>> step_ff[4:0];
      ang = cwc_pkg::atan_angle(step_ff[4:0]);
      z_quad = re_neg_ff ? (ANGLE_PI - z_ff) : z_ff;
      z_sign = im_neg_ff ? (ANGLE_W'(0) - z_quad) : z_quad;
      z_round = z_sign + ANGLE_ROUND;
   end

   // Next-state logic of the post-processing sequencer.
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      mr_in = mr_ff;
      mi_in = mi_ff;
      gsh_in = gsh_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      x_in = x_ff;
      y_in = y_ff;
      xx_in = xx_ff;
      yy_in = yy_ff;
      sq_in = sq_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      px_in = px_ff;
      py_in = py_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      z_in = z_ff;
      re_neg_in = re_neg_ff;
      im_neg_in = im_neg_ff;
      zero_in = zero_ff;
      pos_in = pos_ff;
      fin_in = fin_ff;
      phase_in = phase_ff;
      case (state_ff)
         P_IDLE: begin
            if (start) begin
               mr_in = GP_W'(abs_re);
               mi_in = GP_W'(abs_im);
               gsh_in = gain;
               gx_in = '0;
               gy_in = '0;
               px_in = NW'(abs_re);
               py_in = NW'(abs_im);
               re_neg_in = sum_real[ACC_W-1];
               im_neg_in = sum_imag[ACC_W-1];
               zero_in = (abs_re | abs_im) == '0;
               pos_in = pos;
               fin_in = fin;
               step_in = '0;
               state_in = P_GAIN;
            end
         end
         // Shift-add gain multiply, one gain bit per cycle.
         P_GAIN: begin
            if (gsh_ff[0]) begin
               gx_in = gx_ff + mr_ff;
               gy_in = gy_ff + mi_ff;
            end
            mr_in = mr_ff << 1;
            mi_in = mi_ff << 1;
            gsh_in = gsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(GAIN_W - 1)) begin
               state_in = P_RND;
            end
         end
         P_RND: begin
            x_in = rnd_x[GP_W:FRAC];
            y_in = rnd_y[GP_W:FRAC];
            state_in = P_SQR;
         end
         P_SQR: begin
            xx_in = x_ff * x_ff;
            yy_in = y_ff * y_ff;
            state_in = P_SUM;
         end
         P_SUM: begin
            sq_in = SQ_W'(xx_ff) + SQ_W'(yy_ff);
            rem_in = '0;
            root_in = '0;
            step_in = '0;
            state_in = P_ROOT;
         end
         // Restoring square root, one result bit per cycle.
         P_ROOT: begin
            if (rem_cat >= trial) begin
               rem_in = rem_cat - trial;
               root_in = {root_ff[ROOT_N-2:0], 1'b1};
            end else begin
               rem_in = rem_cat;
               root_in = {root_ff[ROOT_N-2:0], 1'b0};
            end
            sq_in = sq_ff << 2;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_N - 1)) begin
               state_in = P_NORM;
            end
         end
         // Bring the larger component into [2^29, 2^30), one bit per cycle.
         P_NORM: begin
            if (zero_ff) begin
               phase_in = '0;
               state_in = P_OUT;
            end else if (|or_v[NW-1:30]) begin
               px_in = px_ff >> 1;
               py_in = py_ff >> 1;
            end else if (!or_v[29]) begin
               px_in = px_ff << 1;
               py_in = py_ff << 1;
            end else begin
               cx_in = CW'(px_ff[29:0]);
               cy_in = CW'(py_ff[29:0]);
               z_in = '0;
               step_in = '0;
               state_in = P_CORD;
            end
         end
         // One CORDIC vectoring rotation per cycle.
         P_CORD: begin
            if (!cy_ff[CW-1]) begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               z_in = z_ff + ang;
            end else begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               z_in = z_ff - ang;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(cwc_pkg::CORDIC_STEPS - 1)) begin
               state_in = P_FIN;
            end
         end
         P_FIN: begin
            phase_in = z_round[ANGLE_W-1 -: cwc_pkg::PHASE_W];
            state_in = P_OUT;
         end
         P_OUT: begin
            if (!rsp_stall) begin
               state_in = P_IDLE;
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      mr_ff <= mr_in;
      mi_ff <= mi_in;
      gsh_ff <= gsh_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      x_ff <= x_in;
      y_ff <= y_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      sq_ff <= sq_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      px_ff <= px_in;
      py_ff <= py_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff <= z_in;
      re_neg_ff <= re_neg_in;
      im_neg_ff <= im_neg_in;
      zero_ff <= zero_in;
      pos_ff <= pos_in;
      fin_ff <= fin_in;
      phase_ff <= phase_in;
   end

   assign busy = state_ff != P_IDLE;
   assign rsp_valid = state_ff == P_OUT;
   assign rsp_position = pos_ff;
   assign rsp_magnitude = MAG_W'(root_ff);
   assign rsp_phase = phase_ff;
   assign rsp_final_res = fin_ff;
endmodule
`default_nettype wire
